### rtl/core/bfdi_pkg.sv
// ----------------------------------------------------------------------------
// bfdi_pkg
// Shared types and constants for the bloom filter digest indexer.
// ----------------------------------------------------------------------------
package bfdi_pkg;

  // bits per digest byte and per filter row
  localparam int BYTE_BITS = 8;
  localparam int BIT_W     = 3;

  // operation codes carried on the opcode field
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_QUERY = 3'd1,
    OP_QADD  = 3'd2,
    OP_LOAD  = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  // answer kinds on the result channel
  localparam logic KIND_DIGEST = 1'b0;
  localparam logic KIND_READ   = 1'b1;

endpackage

### rtl/core/bfdi_ram.sv
// ----------------------------------------------------------------------------
// bfdi_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module bfdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/bloom_filter_digest_indexer.sv
// ----------------------------------------------------------------------------
// bloom_filter_digest_indexer
// A beat is registered in stage one, its result then in the output register,
// which decouples a stalled result channel. One beat per cycle outside the
// clearing pass; the input stalls only when stage one holds a result while
// an older one waits unaccepted. Reset: rst_n clears control state, then a
// clearing pass zeroes both filter RAMs one byte row a cycle, in_ready low.
// FILTER_BITS must be a power of two (unchecked); filter indexes wrap on it.
// ----------------------------------------------------------------------------
module bloom_filter_digest_indexer #(
  parameter int INDEX_BITS  = 10,
  parameter int FILTER_BITS = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_opcode,
  input  logic [7:0] in_data_byte,
  input  logic [6:0] in_byte_index,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_answer_kind,
  output logic       out_match,
  output logic [7:0] out_read_byte
);

  localparam int BB     = bfdi_pkg::BYTE_BITS;
  localparam int BW     = bfdi_pkg::BIT_W;
  localparam int ROWS   = FILTER_BITS / BB;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int POS_W  = $clog2(FILTER_BITS);
  localparam int FILL_W = $clog2(INDEX_BITS);
  localparam int EXT_W  = INDEX_BITS + BB;
  localparam int IDXP_W = (INDEX_BITS > POS_W) ? INDEX_BITS : POS_W;
  // one spare bit so the row count itself fits for the range compare
  localparam int BIDX_W = ((ROW_W > 7) ? ROW_W : 7) + 1;

  // clearing pass
  logic             clear_r, clear_nxt;
  logic [ROW_W-1:0] clear_cnt_r, clear_cnt_nxt;

  // digest collection state
  logic [INDEX_BITS-1:0] chunk_bits_r, chunk_bits_nxt;
  logic [FILL_W-1:0]     chunk_fill_r, chunk_fill_nxt;
  logic                  miss_seen_r, miss_seen_nxt;

  // stage one registers
  logic             s1_valid_r, s1_valid_nxt;
  bfdi_pkg::op_t    s1_op_r;
  logic             s1_last_r;
  logic             s1_hit_r;
  logic [BW-1:0]    s1_bit_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_rng_r;
  logic             byp_valid_r;
  logic [BB-1:0]    byp_data_r;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r;
  logic          out_match_r;
  logic [BB-1:0] out_byte_r;

  // stage zero signals
  bfdi_pkg::op_t     in_op;
  logic              in_accept;
  logic              in_digest;
  logic [BB-1:0]     rev_byte;
  logic [EXT_W-1:0]  ext_bits;
  logic              idx_hit;
  logic [BW-1:0]     idx_shift;
  logic [INDEX_BITS-1:0] idx_val;
  logic [BB-1:0]     rem_mask;
  logic [IDXP_W-1:0] pos_ext;
  logic [POS_W-1:0]  pos;
  logic [BIDX_W-1:0] bidx_ext;
  logic              bidx_rng;
  logic [ROW_W-1:0]  bidx_row;
  logic [ROW_W-1:0]  local_raddr;

  // stage one signals
  logic          s1_digest;
  logic          s1_has_res;
  logic          s1_go;
  logic [BB-1:0] local_row;
  logic          peer_bit;
  logic          s1_act;
  logic          new_miss;
  logic          miss_now;
  logic          lw_en;
  logic [BB-1:0] lw_data;
  logic          res_kind;
  logic          res_match;
  logic [BB-1:0] res_byte;

  // ram ports
  logic             peer_we, local_we;
  logic [ROW_W-1:0] peer_waddr, local_waddr;
  logic [BB-1:0]    peer_wdata, local_wdata;
  logic [BB-1:0]    peer_rdata, local_rdata;

  // handshake
  assign in_op     = bfdi_pkg::op_t'(in_opcode);
  assign s1_go     = s1_valid_r && (!s1_has_res || !out_valid_r || out_ready);
  assign in_ready  = !clear_r && (!s1_valid_r || s1_go);
  assign in_accept = in_valid && in_ready;
  assign in_digest = (in_op == bfdi_pkg::OP_ADD) || (in_op == bfdi_pkg::OP_QUERY) ||
                     (in_op == bfdi_pkg::OP_QADD);

  // index extraction: bits enter lsb first, first bit lands as msb
  always_comb begin
    for (int j = 0; j < BB; j++) begin
      rev_byte[BB-1-j] = in_data_byte[j];
    end
    ext_bits  = {chunk_bits_r, rev_byte};
    idx_hit   = chunk_fill_r >= FILL_W'(INDEX_BITS - BB);
    idx_shift = BW'(chunk_fill_r - FILL_W'(INDEX_BITS - BB));
    idx_val   = INDEX_BITS'(ext_bits >> idx_shift);
    rem_mask  = BB'(({1'b0, {BB{1'b0}}} | (BB+1)'(1) << idx_shift) - (BB+1)'(1));
    pos_ext   = IDXP_W'(idx_val);
    pos       = pos_ext[POS_W-1:0];
    bidx_ext  = BIDX_W'(in_byte_index);
    bidx_rng  = bidx_ext < BIDX_W'(ROWS);
    bidx_row  = bidx_ext[ROW_W-1:0];
    local_raddr = (in_op == bfdi_pkg::OP_READ) ? bidx_row : pos[POS_W-1:BW];
  end

  // chunk state, speculative: a digest after a miss is gated in stage one
  always_comb begin
    chunk_bits_nxt = chunk_bits_r;
    chunk_fill_nxt = chunk_fill_r;
    if (in_accept && in_digest) begin
      if (in_last) begin
        chunk_bits_nxt = '0;
        chunk_fill_nxt = '0;
      end else if (idx_hit) begin
        chunk_bits_nxt = INDEX_BITS'(rev_byte & rem_mask);
        chunk_fill_nxt = FILL_W'(idx_shift);
      end else begin
        chunk_bits_nxt = ext_bits[INDEX_BITS-1:0];
        chunk_fill_nxt = chunk_fill_r + FILL_W'(BB);
      end
    end
  end

  // stage one: peer test, local update and result
  always_comb begin
    local_row  = byp_valid_r ? byp_data_r : local_rdata;
    peer_bit   = peer_rdata[s1_bit_r];
    s1_digest  = (s1_op_r == bfdi_pkg::OP_ADD) || (s1_op_r == bfdi_pkg::OP_QUERY) ||
                 (s1_op_r == bfdi_pkg::OP_QADD);
    s1_act     = s1_digest && s1_hit_r && !miss_seen_r;
    new_miss   = s1_act && (s1_op_r != bfdi_pkg::OP_ADD) && !peer_bit;
    miss_now   = miss_seen_r || new_miss;
    lw_en      = s1_go && s1_act && ((s1_op_r == bfdi_pkg::OP_ADD) ||
                 ((s1_op_r == bfdi_pkg::OP_QADD) && peer_bit));
    lw_data    = local_row | (BB'(1) << s1_bit_r);
    s1_has_res = 1'b0;
    res_kind   = bfdi_pkg::KIND_DIGEST;
    res_match  = 1'b0;
    res_byte   = '0;
    unique case (s1_op_r)
      bfdi_pkg::OP_ADD, bfdi_pkg::OP_QUERY, bfdi_pkg::OP_QADD: begin
        s1_has_res = s1_last_r;
        res_match  = (s1_op_r == bfdi_pkg::OP_ADD) || !miss_now;
      end
      bfdi_pkg::OP_READ: begin
        s1_has_res = 1'b1;
        res_kind   = bfdi_pkg::KIND_READ;
        res_byte   = s1_rng_r ? local_row : '0;
      end
      default: begin
        s1_has_res = 1'b0;
      end
    endcase
  end

  // miss flag, cleared at digest end
  always_comb begin
    miss_seen_nxt = miss_seen_r;
    if (s1_go && s1_digest) begin
      miss_seen_nxt = s1_last_r ? 1'b0 : miss_now;
    end
  end

  // pipeline valid and output valid
  always_comb begin
    s1_valid_nxt = in_accept || (s1_valid_r && !s1_go);
    if (s1_go && s1_has_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // clearing pass counter
  always_comb begin
    clear_nxt     = clear_r;
    clear_cnt_nxt = clear_cnt_r;
    if (clear_r) begin
      clear_cnt_nxt = clear_cnt_r + ROW_W'(1);
      if (clear_cnt_r == ROW_W'(ROWS - 1)) begin
        clear_nxt = 1'b0;
      end
    end
  end

  // ram write muxing between clearing pass and traffic
  always_comb begin
    peer_we     = clear_r || (in_accept && (in_op == bfdi_pkg::OP_LOAD) && bidx_rng);
    peer_waddr  = clear_r ? clear_cnt_r : bidx_row;
    peer_wdata  = clear_r ? '0 : in_data_byte;
    local_we    = clear_r || lw_en;
    local_waddr = clear_r ? clear_cnt_r : s1_row_r;
    local_wdata = clear_r ? '0 : lw_data;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r      <= 1'b1;
      clear_cnt_r  <= '0;
      chunk_bits_r <= '0;
      chunk_fill_r <= '0;
      miss_seen_r  <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      clear_r      <= clear_nxt;
      clear_cnt_r  <= clear_cnt_nxt;
      chunk_bits_r <= chunk_bits_nxt;
      chunk_fill_r <= chunk_fill_nxt;
      miss_seen_r  <= miss_seen_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // stage one payload, with bypass of a local write landing on the read row
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r     <= in_op;
      s1_last_r   <= in_last;
      s1_hit_r    <= idx_hit;
      s1_bit_r    <= pos[BW-1:0];
      s1_row_r    <= local_raddr;
      s1_rng_r    <= bidx_rng;
      byp_valid_r <= lw_en && (s1_row_r == local_raddr);
      byp_data_r  <= lw_data;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (s1_go && s1_has_res) begin
      out_kind_r  <= res_kind;
      out_match_r <= res_match;
      out_byte_r  <= res_byte;
    end
  end

  // filter stores, one byte row per entry
  bfdi_ram #(
    .WIDTH (BB),
    .DEPTH (ROWS)
  ) u_peer_ram (
    .clk   (clk),
    .we    (peer_we),
    .waddr (peer_waddr),
    .wdata (peer_wdata),
    .re    (in_accept),
    .raddr (pos[POS_W-1:BW]),
    .rdata (peer_rdata)
  );

  bfdi_ram #(
    .WIDTH (BB),
    .DEPTH (ROWS)
  ) u_local_ram (
    .clk   (clk),
    .we    (local_we),
    .waddr (local_waddr),
    .wdata (local_wdata),
    .re    (in_accept),
    .raddr (local_raddr),
    .rdata (local_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_answer_kind = out_kind_r;
  assign out_match       = out_match_r;
  assign out_read_byte   = out_byte_r;

endmodule

### rtl/core/bfdi_chk.sv
// ----------------------------------------------------------------------------
// bfdi_chk
// Port-level checks for the bloom filter digest indexer, bound to the top.
// ----------------------------------------------------------------------------
module bfdi_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_answer_kind,
  input logic       out_match,
  input logic [7:0] out_read_byte
);

  // nothing leaves or enters right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("beat traffic right after reset");

  // a read beat never reports a match
  a_read_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_answer_kind == bfdi_pkg::KIND_READ) |-> !out_match)
    else $error("read beat with match set");

  // a digest answer carries an empty read byte
  a_digest_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_answer_kind == bfdi_pkg::KIND_DIGEST) |-> out_read_byte == 8'd0)
    else $error("digest beat with nonzero read byte");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_answer_kind) &&
    $stable(out_match) && $stable(out_read_byte))
    else $error("result beat changed while stalled");

endmodule

bind bloom_filter_digest_indexer bfdi_chk u_bfdi_chk (.*);
